[rtl/imu9_pkg.sv]
// Shared constants, beat types and control structs of the nine-axis averager.
package imu9_pkg;

  localparam int CHANNELS      = 9;
  localparam int HISTORY_DEPTH = 10;
  localparam int SMP_W         = 16;
  localparam int CH_W          = $clog2(CHANNELS);
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int SUM_W         = SMP_W + SLOT_W;
  localparam int HIST_ADDR_W   = CH_W + SLOT_W;
  localparam int HIST_WORDS    = CHANNELS << SLOT_W;
  localparam int CFG_IDX_W     = 2;

  // Division of a running sum by the history depth as a reciprocal multiply.
  localparam int DIV_SHIFT = SUM_W + SLOT_W;
  localparam int RECIP_W   = SUM_W + 2;
  localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

  // Soft-iron factors as fixed-point encodings of the decimal fractions.
  localparam int SOFT_SHIFT = 35;
  localparam int SOFT_W     = 35;
  localparam longint unsigned FRAC_SCALE = 1000000;
  localparam longint unsigned MAG_Y_SOFT =
      ((64'd783784 << SOFT_SHIFT) + FRAC_SCALE - 1) / FRAC_SCALE;
  localparam longint unsigned MAG_Z_SOFT =
      ((64'd701280 << SOFT_SHIFT) + FRAC_SCALE - 1) / FRAC_SCALE;

  localparam int PRE_W = SMP_W + 2;
  localparam logic signed [PRE_W-1:0] MAG_X_HARD = PRE_W'(238);
  localparam logic signed [PRE_W-1:0] MAG_Y_HARD = PRE_W'(426);
  localparam logic signed [PRE_W-1:0] MAG_Z_HARD = PRE_W'(188);

  typedef logic [CH_W-1:0] ch_t;

  localparam ch_t CH_GYRO_X  = CH_W'(0);
  localparam ch_t CH_GYRO_Y  = CH_W'(1);
  localparam ch_t CH_GYRO_Z  = CH_W'(2);
  localparam ch_t CH_ACCEL_X = CH_W'(3);
  localparam ch_t CH_ACCEL_Y = CH_W'(4);
  localparam ch_t CH_ACCEL_Z = CH_W'(5);
  localparam ch_t CH_MAG_X   = CH_W'(6);
  localparam ch_t CH_MAG_Y   = CH_W'(7);
  localparam ch_t CH_MAG_Z   = CH_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_X_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_Z_OFFSET = CFG_IDX_W'(2);

  typedef struct packed {
    logic signed [SMP_W-1:0] gyro_x_in;
    logic signed [SMP_W-1:0] gyro_y_in;
    logic signed [SMP_W-1:0] gyro_z_in;
    logic signed [SMP_W-1:0] accel_x_in;
    logic signed [SMP_W-1:0] accel_y_in;
    logic signed [SMP_W-1:0] accel_z_in;
    logic signed [SMP_W-1:0] mag_x_in;
    logic signed [SMP_W-1:0] mag_y_in;
    logic signed [SMP_W-1:0] mag_z_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] gyro_x_out;
    logic signed [SMP_W-1:0] gyro_y_out;
    logic signed [SMP_W-1:0] gyro_z_out;
    logic signed [SMP_W-1:0] accel_x_out;
    logic signed [SMP_W-1:0] accel_y_out;
    logic signed [SMP_W-1:0] accel_z_out;
    logic signed [SMP_W-1:0] mag_x_out;
    logic signed [SMP_W-1:0] mag_y_out;
    logic signed [SMP_W-1:0] mag_z_out;
  } out_beat_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_z;
  } offsets_t;

  typedef struct packed {
    logic                    valid;
    ch_t                     ch;
    logic [SLOT_W-1:0]       slot;
    logic                    filled;
    logic                    first;
    logic signed [SMP_W-1:0] sample;
  } issue_t;

  typedef struct packed {
    logic                    valid;
    ch_t                     ch;
    logic signed [SUM_W-1:0] sum;
  } sum_beat_t;

  typedef struct packed {
    logic                    valid;
    ch_t                     ch;
    logic signed [SMP_W-1:0] value;
  } res_beat_t;

endpackage

[rtl/imu9_in_if.sv]
// Sample channel interface carrying one nine-axis sample set per beat.
interface imu9_in_if import imu9_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/imu9_out_if.sv]
// Result channel interface carrying one calibrated nine-axis average per beat.
interface imu9_out_if import imu9_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/imu_nine_axis_average_calibrate.sv]
// Top level of the nine-axis moving averager with offset and iron calibration.
// Sample beats are taken one set at a time: the nine channels are walked one per
// cycle through the history and sum memories and the calibration pipeline, and the
// next sample beat is taken only once the result beat has been loaded for output.
// Reset is synchronous and clears control state and the gyro offsets; fill flags
// make the history and sums read as zero, so no clearing pass is needed.
module imu_nine_axis_average_calibrate import imu9_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  imu9_in_if.sink              samples,
  imu9_out_if.source           results,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SMP_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                  state;
  logic                    issuing;
  ch_t                     issue_ch;
  logic [SLOT_W-1:0]       slot;
  logic                    filled;
  logic                    first;
  offsets_t                offsets;
  logic                    out_valid;
  out_beat_t               out_data;
  logic signed [SMP_W-1:0] smp [CHANNELS];
  logic signed [SMP_W-1:0] res_val [CHANNELS];
  issue_t                  issue;
  sum_beat_t               sum_beat;
  res_beat_t               res_beat;
  logic                    load_out;

  assign samples.ready = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;
  assign load_out      = (state == S_DONE) && (!out_valid || results.ready);

  always_comb begin
    issue.valid  = issuing && (state == S_RUN);
    issue.ch     = issue_ch;
    issue.slot   = slot;
    issue.filled = filled;
    issue.first  = first;
    issue.sample = smp[issue_ch];
  end

  imu9_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .sum_beat (sum_beat)
  );

  imu9_calib u_calib (
    .clk      (clk),
    .rst      (rst),
    .sum_beat (sum_beat),
    .offsets  (offsets),
    .res_beat (res_beat)
  );

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      smp[CH_GYRO_X]  <= samples.data.gyro_x_in;
      smp[CH_GYRO_Y]  <= samples.data.gyro_y_in;
      smp[CH_GYRO_Z]  <= samples.data.gyro_z_in;
      smp[CH_ACCEL_X] <= samples.data.accel_x_in;
      smp[CH_ACCEL_Y] <= samples.data.accel_y_in;
      smp[CH_ACCEL_Z] <= samples.data.accel_z_in;
      smp[CH_MAG_X]   <= samples.data.mag_x_in;
      smp[CH_MAG_Y]   <= samples.data.mag_y_in;
      smp[CH_MAG_Z]   <= samples.data.mag_z_in;
    end
    if (res_beat.valid) begin
      res_val[res_beat.ch] <= res_beat.value;
    end
    if (load_out) begin
      out_data.gyro_x_out  <= res_val[CH_GYRO_X];
      out_data.gyro_y_out  <= res_val[CH_GYRO_Y];
      out_data.gyro_z_out  <= res_val[CH_GYRO_Z];
      out_data.accel_x_out <= res_val[CH_ACCEL_X];
      out_data.accel_y_out <= res_val[CH_ACCEL_Y];
      out_data.accel_z_out <= res_val[CH_ACCEL_Z];
      out_data.mag_x_out   <= res_val[CH_MAG_X];
      out_data.mag_y_out   <= res_val[CH_MAG_Y];
      out_data.mag_z_out   <= res_val[CH_MAG_Z];
    end

    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      issue_ch  <= '0;
      slot      <= '0;
      filled    <= 1'b0;
      first     <= 1'b1;
      offsets   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_GYRO_X_OFFSET: offsets.gyro_x <= cfg_wdata;
          REG_GYRO_Y_OFFSET: offsets.gyro_y <= cfg_wdata;
          REG_GYRO_Z_OFFSET: offsets.gyro_z <= cfg_wdata;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            state    <= S_RUN;
            issuing  <= 1'b1;
            issue_ch <= CH_GYRO_X;
          end
        end
        S_RUN: begin
          if (issuing) begin
            if (issue_ch == CH_MAG_Z) begin
              issuing <= 1'b0;
            end else begin
              issue_ch <= issue_ch + 1'b1;
            end
          end
          if (res_beat.valid && (res_beat.ch == CH_MAG_Z)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
            first <= 1'b0;
            if (slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
              slot   <= '0;
              filled <= 1'b1;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/imu9_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module imu9_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/imu9_accum.sv]
// History and running-sum memories with their read-modify-write update.
module imu9_accum import imu9_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  issue_t    issue,
  output sum_beat_t sum_beat
);

  logic [SMP_W-1:0]        hist_rd;
  logic [SUM_W-1:0]        sum_rd;
  issue_t                  issue_q;
  logic signed [SUM_W-1:0] old_val;
  logic signed [SUM_W-1:0] base_sum;
  logic signed [SUM_W-1:0] new_val;
  logic signed [SUM_W-1:0] sum_next;

  imu9_ram #(
    .WIDTH (SMP_W),
    .DEPTH (HIST_WORDS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (issue_q.valid),
    .waddr ({issue_q.ch, issue_q.slot}),
    .wdata (issue_q.sample),
    .raddr ({issue.ch, issue.slot}),
    .rdata (hist_rd)
  );

  imu9_ram #(
    .WIDTH (SUM_W),
    .DEPTH (CHANNELS)
  ) u_sum_ram (
    .clk   (clk),
    .we    (issue_q.valid),
    .waddr (issue_q.ch),
    .wdata (sum_next),
    .raddr (issue.ch),
    .rdata (sum_rd)
  );

  // Until the ring has wrapped once, the entry being replaced was never
  // written and counts as zero; before the first set, every sum is zero.
  always_comb begin
    old_val  = issue_q.filled ? {{SLOT_W{hist_rd[SMP_W-1]}}, hist_rd} : '0;
    base_sum = issue_q.first ? '0 : sum_rd;
    new_val  = {{SLOT_W{issue_q.sample[SMP_W-1]}}, issue_q.sample};
    sum_next = base_sum - old_val + new_val;
  end

  always_ff @(posedge clk) begin
    sum_beat.ch  <= issue_q.ch;
    sum_beat.sum <= sum_next;
    if (rst) begin
      issue_q        <= '0;
      sum_beat.valid <= 1'b0;
    end else begin
      issue_q        <= issue;
      sum_beat.valid <= issue_q.valid;
    end
  end

endmodule

[rtl/imu9_calib.sv]
// Averaging divide, offset and iron calibration, and saturation pipeline.
module imu9_calib import imu9_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sum_beat_t sum_beat,
  input  offsets_t  offsets,
  output res_beat_t res_beat
);

  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int AVG_W   = SMP_W + 1;
  localparam int SPROD_W = SMP_W + SOFT_W;
  localparam logic signed [PRE_W-1:0] SAT_HI = PRE_W'(32767);
  localparam logic signed [PRE_W-1:0] SAT_LO = PRE_W'(-32768);

  typedef struct packed {
    logic              valid;
    ch_t               ch;
    logic              neg;
    logic [PROD_W-1:0] prod;
  } div_stage_t;

  typedef struct packed {
    logic                    valid;
    ch_t                     ch;
    logic signed [PRE_W-1:0] pre;
  } pre_stage_t;

  typedef struct packed {
    logic                    valid;
    ch_t                     ch;
    logic signed [PRE_W-1:0] pre;
    logic [SPROD_W-1:0]      prod;
  } soft_stage_t;

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [PRE_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SMP_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SMP_W-1:0];
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

  div_stage_t              s1;
  pre_stage_t              s2;
  soft_stage_t             s3;
  logic [SUM_W-1:0]        sum_mag;
  logic [PROD_W-1:0]       div_prod;
  logic [AVG_W-1:0]        avg_mag;
  logic signed [AVG_W-1:0] avg;
  logic signed [PRE_W-1:0] addend;
  logic signed [PRE_W-1:0] pre_next;
  logic signed [PRE_W-1:0] pre_abs;
  logic [SOFT_W-1:0]       soft_mul;
  logic [SPROD_W-1:0]      soft_prod;
  logic                    s3_soft;
  logic [SMP_W-1:0]        soft_q;
  logic signed [PRE_W-1:0] final_val;

  always_comb begin
    sum_mag  = sum_beat.sum[SUM_W-1] ? SUM_W'(-sum_beat.sum) : SUM_W'(sum_beat.sum);
    div_prod = PROD_W'(sum_mag) * PROD_W'(DIV_RECIP);
  end

  always_comb begin
    avg_mag = s1.prod[DIV_SHIFT +: AVG_W];
    avg     = s1.neg ? AVG_W'(-avg_mag) : AVG_W'(avg_mag);
    unique case (s1.ch)
      CH_GYRO_X: addend = -{{2{offsets.gyro_x[SMP_W-1]}}, offsets.gyro_x};
      CH_GYRO_Y: addend = -{{2{offsets.gyro_y[SMP_W-1]}}, offsets.gyro_y};
      CH_GYRO_Z: addend = -{{2{offsets.gyro_z[SMP_W-1]}}, offsets.gyro_z};
      CH_MAG_X:  addend = MAG_X_HARD;
      CH_MAG_Y:  addend = MAG_Y_HARD;
      CH_MAG_Z:  addend = MAG_Z_HARD;
      default:   addend = '0;
    endcase
    pre_next = {avg[AVG_W-1], avg} + addend;
  end

  always_comb begin
    pre_abs   = s2.pre[PRE_W-1] ? PRE_W'(-s2.pre) : s2.pre;
    soft_mul  = (s2.ch == CH_MAG_Y) ? SOFT_W'(MAG_Y_SOFT) : SOFT_W'(MAG_Z_SOFT);
    soft_prod = SPROD_W'(pre_abs[SMP_W-1:0]) * SPROD_W'(soft_mul);
  end

  always_comb begin
    s3_soft = (s3.ch == CH_MAG_Y) || (s3.ch == CH_MAG_Z);
    soft_q  = s3.prod[SOFT_SHIFT +: SMP_W];
    if (s3_soft) begin
      final_val = s3.pre[PRE_W-1] ? -{2'b00, soft_q} : {2'b00, soft_q};
    end else begin
      final_val = s3.pre;
    end
  end

  always_ff @(posedge clk) begin
    s1.ch          <= sum_beat.ch;
    s1.neg         <= sum_beat.sum[SUM_W-1];
    s1.prod        <= div_prod;
    s2.ch          <= s1.ch;
    s2.pre         <= pre_next;
    s3.ch          <= s2.ch;
    s3.pre         <= s2.pre;
    s3.prod        <= soft_prod;
    res_beat.ch    <= s3.ch;
    res_beat.value <= sat16(final_val);
    if (rst) begin
      s1.valid       <= 1'b0;
      s2.valid       <= 1'b0;
      s3.valid       <= 1'b0;
      res_beat.valid <= 1'b0;
    end else begin
      s1.valid       <= sum_beat.valid;
      s2.valid       <= s1.valid;
      s3.valid       <= s2.valid;
      res_beat.valid <= s3.valid;
    end
  end

endmodule

[rtl/imu9_checker.sv]
// Port-level assertions for the nine-axis averager and their bind statement.
module imu9_checker import imu9_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_set_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample beat taken while a set is in progress");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result beat raised right after a sample beat");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed or dropped");

endmodule

bind imu_nine_axis_average_calibrate imu9_checker u_imu9_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
